### hw/rtl/msort_pkg.sv
// Shared types and constants for the merge sort engine.
// No dependencies; every other file of the block but msort_ram imports this package.
package msort_pkg;

    // Default capacity of the element store.
    localparam int MAX_ELEMENTS_DEF = 64;

    // Width of one element.
    localparam int VALUE_W = 32;

    // One input beat: an element and the end-of-set mark.
    typedef struct packed {
        logic signed [VALUE_W-1:0] in_value;
        logic                      in_last;
    } item_t;

    // One output beat: a sorted element and the end-of-run mark.
    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic                      out_last;
    } result_t;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        S_LOAD    = 9'b0_0000_0001,
        S_PAIR    = 9'b0_0000_0010,
        S_RDA     = 9'b0_0000_0100,
        S_RDB     = 9'b0_0000_1000,
        S_MERGE   = 9'b0_0001_0000,
        S_FILL    = 9'b0_0010_0000,
        S_NEXT    = 9'b0_0100_0000,
        S_OUTRD   = 9'b0_1000_0000,
        S_OUTSHOW = 9'b1_0000_0000
    } state_t;

endpackage

### hw/rtl/msort_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// Standalone; no package needed.
module msort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/msort_cmp.sv
// Shared compare unit of the merge step: picks the head of the right run or the left run.
// Uses msort_pkg for the element width.
module msort_cmp (
    input  logic signed [msort_pkg::VALUE_W-1:0] a_val,
    input  logic signed [msort_pkg::VALUE_W-1:0] b_val,
    input  logic                                 a_ok,
    input  logic                                 b_ok,
    output logic                                 take_b
);

    import msort_pkg::*;

    // The right head wins when the left run is empty or when strictly smaller, which keeps the sort stable.
    always_comb
    begin
        take_b = b_ok && (!a_ok || (a_val > b_val));
    end

endmodule

### hw/rtl/merge_sort_engine_unit.sv
// Top level of the merge sort engine: sequencer, ping-pong element stores and output port.
// Depends on msort_pkg, msort_ram and msort_cmp.
//
// Channel | Direction | Payload   | Handshake
// item    | in        | item_t    | item_valid / item_stall
// sorted  | out       | result_t  | sorted_valid / sorted_stall
//
// Loading accepts one beat per cycle; the set is held in one of two RAMs.
// The sort runs ceil(log2 n) passes over the single read port of the source RAM.
// Each output beat is a RAM read, then present, plus any stall time; the next read waits until the beat is taken.
// During sorting and output item_stall is high. Reset clears control state only.
module merge_sort_engine_unit #(
    parameter int MAX_ELEMENTS = msort_pkg::MAX_ELEMENTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  msort_pkg::item_t   item,
    output logic               sorted_valid,
    input  logic               sorted_stall,
    output msort_pkg::result_t sorted
);

    import msort_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int WW = CW + 1;
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [WW-1:0] w_reg, w_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic          src_reg, src_next;
    logic          took_b_reg, took_b_next;
    logic signed [VALUE_W-1:0] a_reg, a_next;
    logic signed [VALUE_W-1:0] b_reg, b_next;

    logic               in_acc;
    logic               out_acc;
    logic               load_we;
    logic               merge_we;
    logic [AW-1:0]      merge_waddr;
    logic signed [VALUE_W-1:0] merge_wdata;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rdata0, rdata1, rdata_src;
    logic               we0, we1;
    logic [AW-1:0]      waddr0;
    logic [VALUE_W-1:0] wdata0;
    logic               a_ok, b_ok, take_b;
    logic [SW-1:0]      lo_w, lo_2w, n_ext, w2;
    logic [CW-1:0]      n_load;
    logic               out_last;

    assign in_acc  = item_valid && !item_stall;
    assign out_acc = sorted_valid && !sorted_stall;

    // Run bounds for the pair starting at lo.
    assign n_ext = SW'(count_reg);
    assign lo_w  = SW'(lo_reg) + SW'(w_reg);
    assign lo_2w = SW'(lo_reg) + (SW'(w_reg) << 1);
    assign w2    = SW'(w_reg) << 1;

    // Set size after the current load beat.
    assign n_load = (count_reg < MAX_C) ? count_reg + CW'(1) : count_reg;

    // Shared compare unit.
    assign a_ok = i_reg < mid_reg;
    assign b_ok = j_reg < hi_reg;

    msort_cmp u_cmp (
        .a_val  (a_reg),
        .b_val  (b_reg),
        .a_ok   (a_ok),
        .b_ok   (b_ok),
        .take_b (take_b)
    );

    assign merge_wdata = take_b ? b_reg : a_reg;
    assign merge_waddr = k_reg[AW-1:0];
    assign out_last    = (k_reg + CW'(1)) == count_reg;

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        w_next      = w_reg;
        lo_next     = lo_reg;
        mid_next    = mid_reg;
        hi_next     = hi_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        src_next    = src_reg;
        took_b_next = took_b_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        load_we     = 1'b0;
        merge_we    = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = k_reg[AW-1:0];
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    load_we    = count_reg < MAX_C;
                    count_next = n_load;
                    if (item.in_last)
                    begin
                        src_next = 1'b0;
                        k_next   = '0;
                        lo_next  = '0;
                        w_next   = WW'(1);
                        if (n_load <= CW'(1))
                        begin
                            state_next = S_OUTRD;
                        end
                        else
                        begin
                            state_next = S_PAIR;
                        end
                    end
                end
            end
            S_PAIR:
            begin
                mid_next   = (lo_w < n_ext) ? lo_w[CW-1:0] : count_reg;
                hi_next    = (lo_2w < n_ext) ? lo_2w[CW-1:0] : count_reg;
                i_next     = lo_reg;
                j_next     = (lo_w < n_ext) ? lo_w[CW-1:0] : count_reg;
                k_next     = lo_reg;
                rd_en      = 1'b1;
                rd_addr    = lo_reg[AW-1:0];
                state_next = S_RDA;
            end
            S_RDA:
            begin
                a_next     = rdata_src;
                rd_en      = 1'b1;
                rd_addr    = j_reg[AW-1:0];
                state_next = S_RDB;
            end
            S_RDB:
            begin
                b_next     = rdata_src;
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                merge_we    = 1'b1;
                took_b_next = take_b;
                rd_en       = 1'b1;
                k_next      = k_reg + CW'(1);
                if (take_b)
                begin
                    j_next  = j_reg + CW'(1);
                    rd_addr = j_next[AW-1:0];
                end
                else
                begin
                    i_next  = i_reg + CW'(1);
                    rd_addr = i_next[AW-1:0];
                end
                if (k_next == hi_reg)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (took_b_reg)
                begin
                    b_next = rdata_src;
                end
                else
                begin
                    a_next = rdata_src;
                end
                state_next = S_MERGE;
            end
            S_NEXT:
            begin
                if (lo_2w >= n_ext)
                begin
                    // Pass complete: the written store becomes the source.
                    src_next = !src_reg;
                    w_next   = w2[WW-1:0];
                    lo_next  = '0;
                    k_next   = '0;
                    if (w2 >= n_ext)
                    begin
                        state_next = S_OUTRD;
                    end
                    else
                    begin
                        state_next = S_PAIR;
                    end
                end
                else
                begin
                    lo_next    = lo_2w[CW-1:0];
                    state_next = S_PAIR;
                end
            end
            S_OUTRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = k_reg[AW-1:0];
                state_next = S_OUTSHOW;
            end
            S_OUTSHOW:
            begin
                if (out_acc)
                begin
                    if (out_last)
                    begin
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + CW'(1);
                        state_next = S_OUTRD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers of the sort; no reset needed.
    always_ff @(posedge clk)
    begin
        w_reg      <= w_next;
        lo_reg     <= lo_next;
        mid_reg    <= mid_next;
        hi_reg     <= hi_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        src_reg    <= src_next;
        took_b_reg <= took_b_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
    end

    // Ping-pong stores: load fills store 0, each pass writes the store that is not the source.
    assign we0    = load_we || (merge_we && src_reg);
    assign we1    = merge_we && !src_reg;
    assign waddr0 = load_we ? count_reg[AW-1:0] : merge_waddr;
    assign wdata0 = load_we ? item.in_value : merge_wdata;

    msort_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store0 (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr0),
        .wdata (wdata0),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata0)
    );

    msort_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store1 (
        .clk   (clk),
        .we    (we1),
        .waddr (merge_waddr),
        .wdata (merge_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata1)
    );

    assign rdata_src = src_reg ? rdata1 : rdata0;

    // Ports.
    assign item_stall       = state_reg != S_LOAD;
    assign sorted_valid     = state_reg == S_OUTSHOW;
    assign sorted.out_value = rdata_src;
    assign sorted.out_last  = out_last;

endmodule

### hw/rtl/msort_checker.sv
// Port-level checker for the merge sort engine, bound to the top level.
// Depends on msort_pkg and merge_sort_engine_unit.
module msort_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input msort_pkg::item_t   item,
    input logic               sorted_valid,
    input logic               sorted_stall,
    input msort_pkg::result_t sorted
);

    import msort_pkg::*;

    // A stalled output beat stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_valid && sorted_stall |=> sorted_valid && $stable(sorted))
        else $error("stalled output beat changed");

    // No input is taken while sorted beats are being delivered.
    a_no_load_in_output: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_valid |-> item_stall)
        else $error("input open during output");

    // The beat that closes a set starts the sort (or the output, for a set of at most one), so input closes next cycle.
    a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.in_last |=> item_stall)
        else $error("input still open after end of set");

    // After the final sorted beat the output goes quiet and input reopens.
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_valid && !sorted_stall && sorted.out_last |=> !sorted_valid && !item_stall)
        else $error("run did not end after final beat");

endmodule

bind merge_sort_engine_unit msort_checker u_msort_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .sorted_valid (sorted_valid),
    .sorted_stall (sorted_stall),
    .sorted       (sorted)
);

### sim/merge_sort_engine_unit_tb.sv
// Self-checking testbench for merge_sort_engine_unit: random and directed sets of signed values.
// Depends on msort_pkg and the engine RTL; a scoreboard class predicts the sorted output beats.
`timescale 1ns / 100ps

module merge_sort_engine_unit_tb;

    import msort_pkg::*;

    localparam int CAPACITY       = MAX_ELEMENTS_DEF;
    localparam int RANDOM_ITEMS   = 380;
    localparam int IDLE_PERCENT   = 11;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 60;
    // A full set sorts in 6 passes without any accepted beat, and the receiver hold-off
    // adds its own stretch on top.
    localparam int STALL_LIMIT    = 12000;

    // Predicts the sorted runs and checks every output beat against them.
    class sort_scoreboard;
        logic signed [VALUE_W-1:0] held_values[$];
        result_t                   sorted_runs[$];
        int                        errors;

        function new();
            errors = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        // An accepted input beat: store it while there is room, sort on the last one.
        function void note_item(input item_t beat);
            logic signed [VALUE_W-1:0] ordered[$];
            logic signed [VALUE_W-1:0] v;
            result_t                   res;
            int                        pos;
            if (held_values.size() < CAPACITY)
                held_values.push_back(beat.in_value);
            if (beat.in_last)
            begin
                // Insertion after the last value that is not greater keeps equal values in
                // load order.
                foreach (held_values[i])
                begin
                    v   = held_values[i];
                    pos = ordered.size();
                    while (pos > 0 && ordered[pos-1] > v)
                        pos--;
                    ordered.insert(pos, v);
                end
                foreach (ordered[i])
                begin
                    res.out_value = ordered[i];
                    res.out_last  = (i == ordered.size() - 1);
                    sorted_runs.push_back(res);
                end
                held_values.delete();
            end
        endfunction

        function int pending();
            return sorted_runs.size();
        endfunction

        // An accepted output beat: compare with the oldest predicted beat.
        task check_result(input result_t got);
            result_t want;
            if (sorted_runs.size() == 0)
            begin
                report($sformatf("unexpected beat value=%0d last=%0b", got.out_value,
                                 got.out_last));
            end
            else
            begin
                want = sorted_runs.pop_front();
                if (got.out_value !== want.out_value)
                    report($sformatf("out_value got %0d want %0d", got.out_value,
                                     want.out_value));
                if (got.out_last !== want.out_last)
                    report($sformatf("out_last got %0b want %0b (value %0d)", got.out_last,
                                     want.out_last, want.out_value));
            end
        endtask

        task check_empty();
            if (sorted_runs.size() != 0)
                report($sformatf("%0d sorted beats never arrived", sorted_runs.size()));
        endtask
    endclass

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    sorted_valid;
    logic    sorted_stall = 1'b0;
    result_t sorted;

    sort_scoreboard sb;
    bit             steady_run        = 1'b0;
    int             holdoff_requests  = 0;
    int             random_sent       = 0;

    merge_sort_engine_unit #(
        .MAX_ELEMENTS(CAPACITY)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .sorted_valid(sorted_valid),
        .sorted_stall(sorted_stall),
        .sorted      (sorted)
    );

    // Clock generation.
    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Offer one beat, idling first at random, and hold it until the engine takes it.
    task automatic send_value(input logic signed [VALUE_W-1:0] value, input logic last);
        item_t beat;
        beat.in_value = value;
        beat.in_last  = last;
        while (!steady_run && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(beat);
    endtask

    // Mostly full-range values, with small values for ties and the extremes mixed in.
    function automatic logic signed [VALUE_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom;
        else if (pick < 80)
            return $signed($urandom_range(0, 15)) - 8;
        else if (pick < 90)
        begin
            case ($urandom_range(0, 3))
                0:       return {1'b1, {(VALUE_W-1){1'b0}}};
                1:       return {1'b0, {(VALUE_W-1){1'b1}}};
                2:       return '0;
                default: return '1;
            endcase
        end
        else
            return {$urandom_range(0, 1) == 0, {(VALUE_W-1){1'b0}}} + $urandom_range(0, 7);
    endfunction

    task automatic send_set(input int size);
        for (int i = 0; i < size; i++)
        begin
            send_value(rand_value(), i == size - 1);
            random_sent++;
        end
    endtask

    // Hold off the sender until every predicted beat has come out.
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
    initial
    begin : receiver
        int  hold_left;
        int  holdoffs_served;
        hold_left       = 0;
        holdoffs_served = 0;
        forever
        begin
            @(posedge clk);
            if (holdoffs_served < holdoff_requests)
            begin
                holdoffs_served++;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                sorted_stall <= 1'b1;
            end
            else
                sorted_stall <= !steady_run && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Output monitor.
    always @(posedge clk)
    begin
        if (rst_n && sorted_valid && !sorted_stall)
            sb.check_result(sorted);
    end

    // Watchdog on cycles without any accepted beat.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (sorted_valid && !sorted_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Main sequence.
    initial
    begin : main_seq
        int  size;
        int  pick;
        bit  holdoff_sent;
        bit  mid_pause_done;
        holdoff_sent   = 1'b0;
        mid_pause_done = 1'b0;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-element sets at the extremes and at zero.
        send_value({1'b0, {(VALUE_W-1){1'b1}}}, 1'b1);
        send_value({1'b1, {(VALUE_W-1){1'b0}}}, 1'b1);
        send_value('0, 1'b1);
        // Mixed signs with both extremes.
        send_value(-1, 1'b0);
        send_value(1, 1'b0);
        send_value({1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
        send_value({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
        send_value('0, 1'b1);
        // Ties must keep load order.
        send_value(5, 1'b0);
        send_value(-5, 1'b0);
        send_value(5, 1'b0);
        send_value(-5, 1'b0);
        send_value(5, 1'b1);
        // Strictly descending, then an already ordered pair.
        for (int v = 3; v >= -2; v--)
            send_value(v, v == -2);
        send_value(-7, 1'b0);
        send_value(7, 1'b1);
        wait_drained();

        // A set that overruns the store: the extra beats are dropped, the last still closes the set.
        send_set(CAPACITY + 3);

        // Random sets, mostly small, a few up to and past capacity.
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                size = $urandom_range(1, 8);
            else if (pick < 92)
                size = $urandom_range(9, 32);
            else if (pick < 98)
                size = $urandom_range(33, CAPACITY);
            else
                size = $urandom_range(CAPACITY + 1, CAPACITY + 6);
            send_set(size);

            // Long receiver hold-off while the sender keeps offering the next set.
            if (!holdoff_sent && random_sent >= 140)
            begin
                holdoff_sent = 1'b1;
                holdoff_requests++;
            end
            steady_run = (random_sent >= 200 && random_sent < 280);
            if (!mid_pause_done && random_sent >= 300)
            begin
                mid_pause_done = 1'b1;
                wait_drained();
            end
        end
        steady_run = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.check_empty();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
